### rtl/ecal_pkg.sv
package ecal_pkg;

    // cycles from an accepted start to its done strobe
    localparam int unsigned ECAL_LATENCY = 9;

    // seconds per day is 675 * 2^7, divided by reciprocal
    localparam logic [9:0]  DAY_DIVISOR    = 10'd675;
    localparam logic [25:0] DAY_RECIP      = 26'd50903316;
    localparam int unsigned DAY_SHIFT      = 35;

    // days are counted in julian four-year cycles from 1968-03-01
    localparam logic [15:0] DAY_2100_MAR1  = 16'd47541;
    localparam logic [15:0] MAR1968_OFFSET = 16'd671;
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
    localparam logic [15:0] CYCLE_RECIP    = 16'd45934;
    localparam int unsigned CYCLE_SHIFT    = 26;
    localparam logic [10:0] DAYS_PER_YEAR  = 11'd365;
    localparam logic [11:0] BASE_YEAR      = 12'd1968;

    // x / 15 and x / 7 by reciprocal, exact over the ranges used here
    localparam logic [15:0] DIV15_RECIP    = 16'd34953;
    localparam int unsigned DIV15_SHIFT    = 19;
    localparam logic [16:0] DIV7_RECIP     = 17'd74899;
    localparam int unsigned DIV7_SHIFT     = 19;
    localparam logic [15:0] DAYS_PER_WEEK  = 16'd7;
    localparam logic [15:0] EPOCH_WEEKDAY  = 16'd4;

    localparam logic [16:0] SEC_PER_MIN    = 17'd60;
    localparam logic [10:0] MIN_PER_HOUR   = 11'd60;

    // march-based month index: january and february follow december
    localparam logic [3:0]  MP_JANUARY     = 4'd10;
    localparam logic [3:0]  MP_LAST        = 4'd11;
    localparam logic [3:0]  MP_TO_MONTH    = 4'd3;
    localparam logic [3:0]  MP_WRAP        = 4'd9;

    typedef struct packed {
        logic        valid;
        logic [15:0] days;
        logic [16:0] rem;
    } ecal_split_t;

    typedef struct packed {
        logic        valid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } ecal_result_t;

    // day of the march-based year on which each month begins
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start_day;
        case (mp)
            4'd0:    start_day = 9'd0;
            4'd1:    start_day = 9'd31;
            4'd2:    start_day = 9'd61;
            4'd3:    start_day = 9'd92;
            4'd4:    start_day = 9'd122;
            4'd5:    start_day = 9'd153;
            4'd6:    start_day = 9'd184;
            4'd7:    start_day = 9'd214;
            4'd8:    start_day = 9'd245;
            4'd9:    start_day = 9'd275;
            4'd10:   start_day = 9'd306;
            4'd11:   start_day = 9'd337;
            default: start_day = 9'd0;
        endcase
        return start_day;
    endfunction

endpackage

### rtl/ecal_day_split.sv
module ecal_day_split import ecal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] epoch_seconds,
    output ecal_split_t split
);

    logic        v1_reg;
    logic [24:0] x1_reg;
    logic [6:0]  lo1_reg;
    logic [50:0] p1_reg;
    logic [50:0] p1_next;

    logic        v2_reg;
    logic [15:0] q2_reg;
    logic [10:0] r2_reg;
    logic [6:0]  lo2_reg;
    logic [15:0] q2_next;
    logic [25:0] r2_full;
    logic [10:0] r2_next;

    logic        v3_reg;
    logic [15:0] days3_reg;
    logic [16:0] rem3_reg;
    logic [15:0] days3_next;
    logic [16:0] rem3_next;
    logic [10:0] r3_fix;

    // stage 1: reciprocal product of the seconds above bit 7
    always_comb
    begin
        p1_next = {26'd0, epoch_seconds[31:7]} * {25'd0, DAY_RECIP};
    end

    // stage 2: estimated day count, possibly one low
    always_comb
    begin
        q2_next = p1_reg[DAY_SHIFT +: 16];
        r2_full = {1'b0, x1_reg} - ({10'd0, q2_next} * {16'd0, DAY_DIVISOR});
        r2_next = r2_full[10:0];
    end

    // stage 3: one correction step
    always_comb
    begin
        if (r2_reg >= {1'b0, DAY_DIVISOR})
        begin
            days3_next = q2_reg + 16'd1;
            r3_fix     = r2_reg - {1'b0, DAY_DIVISOR};
        end
        else
        begin
            days3_next = q2_reg;
            r3_fix     = r2_reg;
        end
        rem3_next = {r3_fix[9:0], lo2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= epoch_seconds[31:7];
        lo1_reg   <= epoch_seconds[6:0];
        p1_reg    <= p1_next;
        q2_reg    <= q2_next;
        r2_reg    <= r2_next;
        lo2_reg   <= lo1_reg;
        days3_reg <= days3_next;
        rem3_reg  <= rem3_next;
    end

    assign split.valid = v3_reg;
    assign split.days  = days3_reg;
    assign split.rem   = rem3_reg;

endmodule

### rtl/ecal_calendar.sv
module ecal_calendar import ecal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ecal_split_t  split,
    output ecal_result_t result
);

    // stage 4
    logic        v4_reg;
    logic [15:0] z4_reg;
    logic [15:0] wx4_reg;
    logic [16:0] rem4_reg;
    logic [30:0] pm4_reg;
    logic [15:0] z4_next;
    logic [15:0] wx4_next;
    logic [30:0] pm4_next;
    logic        after_2100_feb;

    // stage 5
    logic        v5_reg;
    logic [15:0] z5_reg;
    logic [15:0] wx5_reg;
    logic [31:0] pc5_reg;
    logic [32:0] pw5_reg;
    logic [10:0] m5_reg;
    logic [5:0]  sec5_reg;
    logic [31:0] pc5_next;
    logic [32:0] pw5_next;
    logic [10:0] m5_next;
    logic [16:0] sec5_full;

    // stage 6
    logic        v6_reg;
    logic [5:0]  cycle6_reg;
    logic [10:0] doc6_reg;
    logic [2:0]  wd6_reg;
    logic [24:0] ph6_reg;
    logic [10:0] m6_reg;
    logic [5:0]  sec6_reg;
    logic [5:0]  cycle6_next;
    logic [15:0] doc6_full;
    logic [12:0] q7;
    logic [15:0] wd6_full;
    logic [24:0] ph6_next;

    // stage 7
    logic        v7_reg;
    logic [8:0]  doy7_reg;
    logic [11:0] year7_reg;
    logic [4:0]  hr7_reg;
    logic [5:0]  mn7_reg;
    logic [2:0]  wd7_reg;
    logic [5:0]  sec7_reg;
    logic [1:0]  yoc;
    logic [10:0] doy7_full;
    logic [11:0] year7_next;
    logic [4:0]  hr7_next;
    logic [10:0] mn7_full;

    // stage 8
    logic        v8_reg;
    logic [3:0]  mp8_reg;
    logic [8:0]  doy8_reg;
    logic [11:0] year8_reg;
    logic [4:0]  hr8_reg;
    logic [5:0]  mn8_reg;
    logic [2:0]  wd8_reg;
    logic [5:0]  sec8_reg;
    logic [3:0]  mp8_next;

    // stage 9
    logic        v9_reg;
    logic [11:0] year9_reg;
    logic [3:0]  mon9_reg;
    logic [4:0]  dom9_reg;
    logic [4:0]  hr9_reg;
    logic [5:0]  mn9_reg;
    logic [2:0]  wd9_reg;
    logic [5:0]  sec9_reg;
    logic [11:0] year9_next;
    logic [3:0]  mon9_next;
    logic [8:0]  dom9_full;

    // stage 4: insert a phantom feb 29 2100 so four-year cycles hold throughout
    always_comb
    begin
        after_2100_feb = (split.days >= DAY_2100_MAR1);
        z4_next  = split.days + MAR1968_OFFSET + {15'd0, after_2100_feb};
        wx4_next = split.days + EPOCH_WEEKDAY;
        pm4_next = {16'd0, split.rem[16:2]} * {15'd0, DIV15_RECIP};
    end

    // stage 5: minutes of day, seconds, cycle and weekday products
    always_comb
    begin
        pc5_next  = {16'd0, z4_reg} * {16'd0, CYCLE_RECIP};
        pw5_next  = {17'd0, wx4_reg} * {16'd0, DIV7_RECIP};
        m5_next   = pm4_reg[DIV15_SHIFT +: 11];
        sec5_full = rem4_reg - ({6'd0, m5_next} * SEC_PER_MIN);
    end

    // stage 6: day of cycle, weekday, hour product
    always_comb
    begin
        cycle6_next = pc5_reg[CYCLE_SHIFT +: 6];
        doc6_full   = z5_reg - ({10'd0, cycle6_next} * {5'd0, DAYS_PER_CYCLE});
        q7          = pw5_reg[DIV7_SHIFT +: 13];
        wd6_full    = wx5_reg - ({3'd0, q7} * DAYS_PER_WEEK);
        ph6_next    = {16'd0, m5_reg[10:2]} * {9'd0, DIV15_RECIP};
    end

    // stage 7: year of cycle, day of year, hour and minute
    always_comb
    begin
        yoc = 2'd0;
        if (doc6_reg >= 3'd3 * DAYS_PER_YEAR)
        begin
            yoc = 2'd3;
        end
        else if (doc6_reg >= 2'd2 * DAYS_PER_YEAR)
        begin
            yoc = 2'd2;
        end
        else if (doc6_reg >= DAYS_PER_YEAR)
        begin
            yoc = 2'd1;
        end
        doy7_full  = doc6_reg - ({9'd0, yoc} * DAYS_PER_YEAR);
        year7_next = BASE_YEAR + {4'd0, cycle6_reg, 2'b00} + {10'd0, yoc};
        hr7_next   = ph6_reg[DIV15_SHIFT +: 5];
        mn7_full   = m6_reg - ({6'd0, hr7_next} * MIN_PER_HOUR);
    end

    // stage 8: month index from ordered thresholds
    always_comb
    begin
        mp8_next = 4'd0;
        for (int k = 1; k <= int'(MP_LAST); k++)
        begin
            if (doy7_reg >= month_start(4'(k)))
            begin
                mp8_next = 4'(k);
            end
        end
    end

    // stage 9: day of month, calendar month and year
    always_comb
    begin
        dom9_full = doy8_reg - month_start(mp8_reg) + 9'd1;
        if (mp8_reg < MP_JANUARY)
        begin
            mon9_next  = mp8_reg + MP_TO_MONTH;
            year9_next = year8_reg;
        end
        else
        begin
            mon9_next  = mp8_reg - MP_WRAP;
            year9_next = year8_reg + 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= split.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z4_reg     <= z4_next;
        wx4_reg    <= wx4_next;
        rem4_reg   <= split.rem;
        pm4_reg    <= pm4_next;

        z5_reg     <= z4_reg;
        wx5_reg    <= wx4_reg;
        pc5_reg    <= pc5_next;
        pw5_reg    <= pw5_next;
        m5_reg     <= m5_next;
        sec5_reg   <= sec5_full[5:0];

        cycle6_reg <= cycle6_next;
        doc6_reg   <= doc6_full[10:0];
        wd6_reg    <= wd6_full[2:0];
        ph6_reg    <= ph6_next;
        m6_reg     <= m5_reg;
        sec6_reg   <= sec5_reg;

        doy7_reg   <= doy7_full[8:0];
        year7_reg  <= year7_next;
        hr7_reg    <= hr7_next;
        mn7_reg    <= mn7_full[5:0];
        wd7_reg    <= wd6_reg;
        sec7_reg   <= sec6_reg;

        mp8_reg    <= mp8_next;
        doy8_reg   <= doy7_reg;
        year8_reg  <= year7_reg;
        hr8_reg    <= hr7_reg;
        mn8_reg    <= mn7_reg;
        wd8_reg    <= wd7_reg;
        sec8_reg   <= sec7_reg;

        year9_reg  <= year9_next;
        mon9_reg   <= mon9_next;
        dom9_reg   <= dom9_full[4:0];
        hr9_reg    <= hr8_reg;
        mn9_reg    <= mn8_reg;
        wd9_reg    <= wd8_reg;
        sec9_reg   <= sec8_reg;
    end

    assign result.valid        = v9_reg;
    assign result.year         = year9_reg;
    assign result.month        = mon9_reg;
    assign result.day_of_month = dom9_reg;
    assign result.weekday      = wd9_reg;
    assign result.hour         = hr9_reg;
    assign result.minute       = mn9_reg;
    assign result.second       = sec9_reg;

endmodule

### rtl/epoch_seconds_to_calendar.sv
// done pulses when a transfer taken on start leaves the last pipeline stage
// throughput: one transfer per cycle through a 9-stage pipeline, busy is always low
// reciprocal multiplies stand in for every divide, at most two in a stage
// the day split sets the first three stages
// reset clears every stage valid bit, items in flight at reset are dropped
// the receiver cannot stall, so results leave on done without back pressure
module epoch_seconds_to_calendar import ecal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    ecal_split_t  split;
    ecal_result_t result;
    logic         accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ecal_day_split u_day_split
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .epoch_seconds (epoch_seconds),
        .split         (split)
    );

    ecal_calendar u_calendar
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .split  (split),
        .result (result)
    );

    assign done         = result.valid;
    assign year         = result.year;
    assign month        = result.month;
    assign day_of_month = result.day_of_month;
    assign weekday      = result.weekday;
    assign hour         = result.hour;
    assign minute       = result.minute;
    assign second       = result.second;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##ECAL_LATENCY done)
        else $error("transfer did not complete at pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, ECAL_LATENCY))
        else $error("done without matching transfer");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
                  && year >= 12'd1970 && year <= 12'd2106 && weekday <= 3'd6))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("time field out of range");
`endif

endmodule
